@@ src/bba_pkg.sv @@
// ----------------------------------------------------------------------------
// bba_pkg
// shared types and constants of the buddy block allocator
// ----------------------------------------------------------------------------
package bba_pkg;

    localparam int BYTES_W  = 16;
    localparam int OFF_W    = 16;
    localparam int GLVL_W   = 5;
    localparam int ST_W     = 2;
    localparam int HDR_W    = 6;
    localparam int APB_AW   = 2;
    localparam int APB_DW   = 32;

    localparam logic [HDR_W-1:0]  HDR_RESET = 6'd32;
    localparam logic [APB_AW-1:0] ADDR_HDR  = 2'd0;

    typedef enum logic [ST_W-1:0] {
        ST_OK       = 2'd0,
        ST_NO_SPACE = 2'd1,
        ST_BAD_FREE = 2'd2
    } t_status;

    typedef enum logic {
        ACT_ALLOC = 1'b0,
        ACT_FREE  = 1'b1
    } t_action;

endpackage

@@ src/bba_if.sv @@
// ----------------------------------------------------------------------------
// bba_req_if / bba_rsp_if
// request and response channels of the buddy block allocator
// ----------------------------------------------------------------------------
interface bba_req_if import bba_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               action;
    logic [BYTES_W-1:0] request_bytes;
    logic [OFF_W-1:0]   data_offset;

    modport source (output valid, action, request_bytes, data_offset, input ready);
    modport sink   (input valid, action, request_bytes, data_offset, output ready);
endinterface

interface bba_rsp_if import bba_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [OFF_W-1:0]  result_offset;
    logic [GLVL_W-1:0] granted_level;
    logic [ST_W-1:0]   status;

    modport source (output valid, result_offset, granted_level, status, input ready);
    modport sink   (input valid, result_offset, granted_level, status, output ready);
endinterface

@@ src/bba_ram.sv @@
// ----------------------------------------------------------------------------
// bba_ram
// simple dual-port ram, one write port, one read port with registered data
// ----------------------------------------------------------------------------
module bba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

@@ src/buddy_block_allocator.sv @@
// ----------------------------------------------------------------------------
// buddy_block_allocator
// binary buddy allocator with per-level free lists linked through one ram
// ----------------------------------------------------------------------------
// The arena of 2^ARENA_LEVEL bytes is cut into 2^(ARENA_LEVEL-MIN_LEVEL)
// slots; every slot has one ram word (level, free, used, next, prev links).
// After reset a clearing pass writes every word, one per cycle, so the block
// takes no request until the pass is done; register writes are taken
// throughout. One request is handled at a time. An allocate scans the levels
// upward from the wanted level, takes the list head and relinks its successor
// if it has one, then splits the block down, pushing each buddy half on its
// free list; a free reads the slot, then per merge step reads the buddy and
// unlinks it, and a free with a bad offset is rejected without a ram read. The
// single ram read port sets the pace, each link update being a read followed
// by a write-back. A result waits in an output register while the next
// request is accepted.
// ----------------------------------------------------------------------------
module buddy_block_allocator
    import bba_pkg::*;
#(
    parameter int ARENA_LEVEL = 16,
    parameter int MIN_LEVEL   = 6
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    bba_req_if.sink           i_req,
    bba_rsp_if.source         o_rsp,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    localparam int SW    = ARENA_LEVEL - MIN_LEVEL;
    localparam int NSLOT = 1 << SW;
    localparam int LMAX  = (ARENA_LEVEL > BYTES_W + 1) ? ARENA_LEVEL : BYTES_W + 1;
    localparam int LW    = $clog2(LMAX + 2);
    localparam int HW    = $clog2(ARENA_LEVEL + 1);
    localparam int NLVL  = ARENA_LEVEL + 1;

    localparam logic [SW:0]      NIL      = {1'b1, {SW{1'b0}}};
    localparam logic [LW-1:0]    L_ARENA  = LW'(ARENA_LEVEL);
    localparam logic [LW-1:0]    L_MIN    = LW'(MIN_LEVEL);
    localparam logic [OFF_W-1:0] OFF_MASK = OFF_W'((1 << MIN_LEVEL) - 1);

    typedef struct packed {
        logic [LW-1:0] lvl;
        logic          free;
        logic          used;
        logic [SW:0]   nxt;
        logic [SW:0]   prv;
    } t_entry;

    localparam int EW = $bits(t_entry);

    typedef enum logic [3:0] {
        S_CLR, S_IDLE, S_A_SRCH, S_A_RD, S_A_NRD, S_A_SPLIT,
        S_F_RD, S_F_BUD, S_F_BRD, S_U_PRD, S_U_NRD, S_F_END,
        S_PUSH_FIX, S_DONE
    } t_state;

    t_state             r_state, n_state, r_ret, n_ret;
    logic [SW-1:0]      r_cnt, n_cnt;
    logic [HDR_W-1:0]   r_hdr, n_hdr;
    logic [SW-1:0]      r_head [NLVL];
    logic [SW-1:0]      n_head [NLVL];
    logic [NLVL-1:0]    r_ne, n_ne;
    logic [LW-1:0]      r_lvl, n_lvl, r_want, n_want;
    logic [SW-1:0]      r_s, n_s, r_b, n_b;
    logic [SW:0]        r_p, n_p, r_n, n_n;
    logic [OFF_W-1:0]   r_res_off, n_res_off;
    logic [GLVL_W-1:0]  r_res_lvl, n_res_lvl;
    t_status            r_res_st, n_res_st;
    logic               r_ovld, n_ovld;
    logic [OFF_W-1:0]   r_o_off, n_o_off;
    logic [GLVL_W-1:0]  r_o_lvl, n_o_lvl;
    t_status            r_o_st, n_o_st;

    logic               mem_we;
    logic [SW-1:0]      mem_waddr, mem_raddr;
    t_entry             mem_wdata;
    logic [EW-1:0]      mem_rdata;
    t_entry             rd;

    assign rd = t_entry'(mem_rdata);

    bba_ram #(
        .WIDTH (EW),
        .DEPTH (NSLOT)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign i_req.ready         = (r_state == S_IDLE);
    assign o_rsp.valid         = r_ovld;
    assign o_rsp.result_offset = r_o_off;
    assign o_rsp.granted_level = r_o_lvl;
    assign o_rsp.status        = r_o_st;
    assign pready              = 1'b1;
    assign prdata              = (paddr == ADDR_HDR) ? APB_DW'(r_hdr) : '0;

    always_comb begin
        logic [BYTES_W:0]   tot;
        logic [LW-1:0]      blen;
        logic [LW-1:0]      want_c;
        logic [OFF_W-1:0]   start;
        logic               bad_c;
        logic [SW-1:0]      s_c;
        logic [HW-1:0]      idx;
        logic [HW-1:0]      pidx;
        logic               do_push;
        logic [SW-1:0]      pb;
        logic [LW-1:0]      pl;
        t_state             pret;
        logic [LW-1:0]      l1;
        logic [SW-1:0]      sz;
        logic               finish;
        t_entry             w;

        n_state   = r_state;
        n_ret     = r_ret;
        n_cnt     = r_cnt;
        n_hdr     = r_hdr;
        n_head    = r_head;
        n_ne      = r_ne;
        n_lvl     = r_lvl;
        n_want    = r_want;
        n_s       = r_s;
        n_b       = r_b;
        n_p       = r_p;
        n_n       = r_n;
        n_res_off = r_res_off;
        n_res_lvl = r_res_lvl;
        n_res_st  = r_res_st;
        n_ovld    = r_ovld;
        n_o_off   = r_o_off;
        n_o_lvl   = r_o_lvl;
        n_o_st    = r_o_st;
        mem_we    = 1'b0;
        mem_waddr = '0;
        mem_wdata = '0;
        mem_raddr = '0;
        do_push   = 1'b0;
        pb        = r_s;
        pl        = r_lvl;
        pret      = S_F_END;
        finish    = 1'b0;
        w         = rd;

        if (psel && penable && pwrite && (paddr == ADDR_HDR)) begin
            n_hdr = pwdata[HDR_W-1:0];
        end

        // level needed by an allocate: bit length of payload plus header, at least MIN_LEVEL
        tot  = {1'b0, i_req.request_bytes} + (BYTES_W + 1)'(r_hdr);
        blen = '0;
        for (int i = 0; i <= BYTES_W; i++) begin
            if (tot[i]) begin
                blen = LW'(i + 1);
            end
        end
        want_c = (blen < L_MIN) ? L_MIN : blen;

        start = i_req.data_offset - OFF_W'(r_hdr);
        bad_c = (i_req.data_offset < OFF_W'(r_hdr)) || ((start & OFF_MASK) != '0)
              || ((32'(start) >> ARENA_LEVEL) != 32'd0);
        s_c   = SW'(32'(start) >> MIN_LEVEL);

        idx = r_lvl[HW-1:0];
        l1  = r_lvl - LW'(1);
        sz  = SW'(1) << (r_lvl - L_MIN);

        if (r_ovld && o_rsp.ready) begin
            n_ovld = 1'b0;
        end

        unique case (r_state)
            S_CLR: begin
                mem_we    = 1'b1;
                mem_waddr = r_cnt;
                if (r_cnt == '0) begin
                    mem_wdata = '{lvl: L_ARENA, free: 1'b1, used: 1'b0, nxt: NIL, prv: NIL};
                end
                n_cnt = r_cnt + SW'(1);
                if (r_cnt == '1) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_req.valid) begin
                    if (i_req.action == ACT_ALLOC) begin
                        n_want  = want_c;
                        n_lvl   = want_c;
                        n_state = S_A_SRCH;
                    end else if (bad_c) begin
                        n_res_off = '0;
                        n_res_lvl = '0;
                        n_res_st  = ST_BAD_FREE;
                        n_state   = S_DONE;
                    end else begin
                        mem_raddr = s_c;
                        n_s       = s_c;
                        n_state   = S_F_RD;
                    end
                end
            end
            S_A_SRCH: begin
                if (r_lvl > L_ARENA) begin
                    n_res_off = '0;
                    n_res_lvl = '0;
                    n_res_st  = ST_NO_SPACE;
                    n_state   = S_DONE;
                end else if (r_ne[idx]) begin
                    n_s       = r_head[idx];
                    mem_raddr = r_head[idx];
                    n_state   = S_A_RD;
                end else begin
                    n_lvl = r_lvl + LW'(1);
                end
            end
            S_A_RD: begin
                // the list head has no predecessor
                if (rd.nxt == NIL) begin
                    n_ne[idx] = 1'b0;
                    n_state   = S_A_SPLIT;
                end else begin
                    n_head[idx] = rd.nxt[SW-1:0];
                    mem_raddr   = rd.nxt[SW-1:0];
                    n_n         = rd.nxt;
                    n_state     = S_A_NRD;
                end
            end
            S_A_NRD: begin
                w.prv     = NIL;
                mem_we    = 1'b1;
                mem_waddr = r_n[SW-1:0];
                mem_wdata = w;
                n_state   = S_A_SPLIT;
            end
            S_A_SPLIT: begin
                if (r_lvl > r_want) begin
                    do_push = 1'b1;
                    pb      = r_s + (SW'(1) << (l1 - L_MIN));
                    pl      = l1;
                    pret    = S_A_SPLIT;
                    n_lvl   = l1;
                end else begin
                    mem_we    = 1'b1;
                    mem_waddr = r_s;
                    mem_wdata = '{lvl: r_want, free: 1'b0, used: 1'b1, nxt: NIL, prv: NIL};
                    n_res_off = OFF_W'((32'(r_s) << MIN_LEVEL) + 32'(r_hdr));
                    n_res_lvl = GLVL_W'(r_want);
                    n_res_st  = ST_OK;
                    n_state   = S_DONE;
                end
            end
            S_F_RD: begin
                if (!rd.used) begin
                    n_res_off = '0;
                    n_res_lvl = '0;
                    n_res_st  = ST_BAD_FREE;
                    n_state   = S_DONE;
                end else begin
                    w.used    = 1'b0;
                    mem_we    = 1'b1;
                    mem_waddr = r_s;
                    mem_wdata = w;
                    n_lvl     = rd.lvl;
                    n_state   = S_F_BUD;
                end
            end
            S_F_BUD: begin
                if (r_lvl >= L_ARENA) begin
                    do_push = 1'b1;
                end else begin
                    mem_raddr = r_s ^ sz;
                    n_b       = r_s ^ sz;
                    n_state   = S_F_BRD;
                end
            end
            S_F_BRD: begin
                if (rd.free && (rd.lvl == r_lvl)) begin
                    // unlink the buddy and merge
                    w.free    = 1'b0;
                    mem_we    = 1'b1;
                    mem_waddr = r_b;
                    mem_wdata = w;
                    n_p       = rd.prv;
                    n_n       = rd.nxt;
                    if (rd.prv == NIL) begin
                        if (rd.nxt == NIL) begin
                            n_ne[idx] = 1'b0;
                        end else begin
                            n_head[idx] = rd.nxt[SW-1:0];
                        end
                    end
                    n_s   = r_s & ~sz;
                    n_lvl = r_lvl + LW'(1);
                    if (rd.prv != NIL) begin
                        mem_raddr = rd.prv[SW-1:0];
                        n_state   = S_U_PRD;
                    end else if (rd.nxt != NIL) begin
                        mem_raddr = rd.nxt[SW-1:0];
                        n_state   = S_U_NRD;
                    end else begin
                        n_state = S_F_BUD;
                    end
                end else begin
                    do_push = 1'b1;
                end
            end
            S_U_PRD: begin
                w.nxt     = r_n;
                mem_we    = 1'b1;
                mem_waddr = r_p[SW-1:0];
                mem_wdata = w;
                if (r_n != NIL) begin
                    mem_raddr = r_n[SW-1:0];
                    n_state   = S_U_NRD;
                end else begin
                    n_state = S_F_BUD;
                end
            end
            S_U_NRD: begin
                w.prv     = r_p;
                mem_we    = 1'b1;
                mem_waddr = r_n[SW-1:0];
                mem_wdata = w;
                n_state   = S_F_BUD;
            end
            S_F_END: begin
                n_res_off = '0;
                n_res_lvl = GLVL_W'(r_lvl);
                n_res_st  = ST_OK;
                n_state   = S_DONE;
            end
            S_PUSH_FIX: begin
                // old list head points back at the pushed block
                w.prv     = {1'b0, r_b};
                mem_we    = 1'b1;
                mem_waddr = r_n[SW-1:0];
                mem_wdata = w;
                n_state   = r_ret;
            end
            S_DONE: begin
                finish = !r_ovld || o_rsp.ready;
                if (finish) begin
                    n_ovld  = 1'b1;
                    n_o_off = r_res_off;
                    n_o_lvl = r_res_lvl;
                    n_o_st  = r_res_st;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (do_push) begin
            pidx      = pl[HW-1:0];
            mem_we    = 1'b1;
            mem_waddr = pb;
            mem_wdata = '{lvl: pl, free: 1'b1, used: 1'b0,
                          nxt: r_ne[pidx] ? {1'b0, r_head[pidx]} : NIL, prv: NIL};
            n_b          = pb;
            n_head[pidx] = pb;
            n_ne[pidx]   = 1'b1;
            if (r_ne[pidx]) begin
                mem_raddr = r_head[pidx];
                n_n       = {1'b0, r_head[pidx]};
                n_ret     = pret;
                n_state   = S_PUSH_FIX;
            end else begin
                n_state = pret;
            end
        end else begin
            pidx = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_ret   <= S_IDLE;
            r_cnt   <= '0;
            r_hdr   <= HDR_RESET;
            r_head  <= '{default: '0};
            r_ne    <= NLVL'(1) << ARENA_LEVEL;
            r_ovld  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
            r_cnt   <= n_cnt;
            r_hdr   <= n_hdr;
            r_head  <= n_head;
            r_ne    <= n_ne;
            r_ovld  <= n_ovld;
        end
        r_lvl     <= n_lvl;
        r_want    <= n_want;
        r_s       <= n_s;
        r_b       <= n_b;
        r_p       <= n_p;
        r_n       <= n_n;
        r_res_off <= n_res_off;
        r_res_lvl <= n_res_lvl;
        r_res_st  <= n_res_st;
        r_o_off   <= n_o_off;
        r_o_lvl   <= n_o_lvl;
        r_o_st    <= n_o_st;
    end

endmodule

@@ tb/sv/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the buddy block allocator: requests are driven from
// a queue, every response is compared with a behavioral allocator model kept
// in step with each accepted request, under several header sizes
// ----------------------------------------------------------------------------
module tb_top;
    import bba_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int ARENA = 16;
    localparam int MINL  = 6;
    localparam int NSLOT = 1 << (ARENA - MINL);
    localparam int NIL   = NSLOT;

    typedef struct packed {
        t_action           act;
        logic [BYTES_W-1:0] nbytes;
        logic [OFF_W-1:0]   doff;
    } t_req;

    typedef struct packed {
        logic [OFF_W-1:0]  off;
        logic [GLVL_W-1:0] lvl;
        t_status           st;
    } t_rsp;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [APB_AW-1:0] paddr = '0;
    logic [APB_DW-1:0] pwdata = '0;
    logic [APB_DW-1:0] prdata;
    logic pready;

    bba_req_if req_ch ();
    bba_rsp_if rsp_ch ();

    buddy_block_allocator dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(req_ch.sink), .o_rsp(rsp_ch.source),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // model state
    int unsigned hdr_sz;
    int unsigned head_of[ARENA+1];
    logic [ARENA:0] lvl_busy;
    int unsigned blk_lvl[NSLOT];
    bit blk_free[NSLOT];
    bit blk_used[NSLOT];
    int unsigned nxt[NSLOT];
    int unsigned prv[NSLOT];
    int unsigned live_offs[$];

    t_req pending_reqs[$];
    t_rsp expected_rsps[$];
    int   n_errors = 0;
    int   n_sent = 0;
    bit   hold_sender = 1'b0;

    function automatic void push_free(int unsigned s, int unsigned l);
        blk_lvl[s] = l;
        blk_free[s] = 1'b1;
        prv[s] = NIL;
        if (lvl_busy[l]) begin
            nxt[s] = head_of[l];
            prv[head_of[l]] = s;
        end else begin
            nxt[s] = NIL;
            lvl_busy[l] = 1'b1;
        end
        head_of[l] = s;
    endfunction

    function automatic void unlink_free(int unsigned s);
        int unsigned l, p, n;
        l = blk_lvl[s];
        p = prv[s];
        n = nxt[s];
        if (p == NIL) begin
            if (n == NIL) lvl_busy[l] = 1'b0;
            else head_of[l] = n;
        end else begin
            nxt[p] = n;
        end
        if (n != NIL) prv[n] = p;
        blk_free[s] = 1'b0;
    endfunction

    function automatic void arena_reset();
        hdr_sz = HDR_RESET;
        lvl_busy = '0;
        foreach (blk_free[i]) begin
            blk_free[i] = 1'b0;
            blk_used[i] = 1'b0;
            blk_lvl[i] = 0;
        end
        push_free(0, ARENA);
    endfunction

    function automatic t_rsp allocate_or_free(t_req r);
        t_rsp o;
        int unsigned tot, want, l, s, start, sz, b;
        bit found;
        o.off = '0;
        o.lvl = '0;
        o.st = ST_OK;
        if (r.act == ACT_ALLOC) begin
            tot = r.nbytes + hdr_sz;
            want = 0;
            while (tot != 0) begin
                tot >>= 1;
                want++;
            end
            if (want < MINL) want = MINL;
            found = 1'b0;
            for (l = want; l <= ARENA; l++)
                if (lvl_busy[l]) begin
                    found = 1'b1;
                    break;
                end
            if (!found) begin
                o.st = ST_NO_SPACE;
            end else begin
                s = head_of[l];
                unlink_free(s);
                while (l > want) begin
                    l--;
                    push_free(s + (1 << (l - MINL)), l);
                end
                blk_lvl[s] = want;
                blk_used[s] = 1'b1;
                o.off = OFF_W'((s << MINL) + hdr_sz);
                o.lvl = GLVL_W'(want);
                live_offs.push_back(o.off);
            end
        end else begin
            start = r.doff - hdr_sz;
            s = start >> MINL;
            if (r.doff < hdr_sz || (start & ((1 << MINL) - 1)) != 0 || s >= NSLOT
                    || !blk_used[s]) begin
                o.st = ST_BAD_FREE;
            end else begin
                blk_used[s] = 1'b0;
                l = blk_lvl[s];
                while (l < ARENA) begin
                    sz = 1 << (l - MINL);
                    b = s ^ sz;
                    if (b < NSLOT && blk_free[b] && blk_lvl[b] == l) begin
                        unlink_free(b);
                        s &= ~sz;
                        l++;
                    end else begin
                        break;
                    end
                end
                push_free(s, l);
                o.lvl = GLVL_W'(l);
            end
        end
        return o;
    endfunction

    // mostly no gap, often short gaps, occasionally long ones
    function automatic int gap_len();
        int p;
        p = $urandom_range(99);
        if (p < 55) return 0;
        if (p < 92) return $urandom_range(3, 1);
        return $urandom_range(40, 8);
    endfunction

    task automatic report_mismatch(string what, int got, int exp_v);
        $display("mismatch %s: got %0d expected %0d", what, got, exp_v);
        n_errors++;
    endtask

    // request transaction taken at the last rising edge
    bit req_acc = 1'b0;
    always @(posedge i_clk) begin
        req_acc <= req_ch.valid && req_ch.ready;
    end

    // driver
    int send_gap = 0;
    always @(negedge i_clk) begin
        t_req r;
        if (!i_rst_n) begin
            req_ch.valid <= 1'b0;
        end else if (req_ch.valid && !req_acc) begin
        end else begin
            if (req_ch.valid) begin
                r = '{t_action'(req_ch.action), req_ch.request_bytes, req_ch.data_offset};
                expected_rsps.push_back(allocate_or_free(r));
                n_sent++;
            end
            if (send_gap > 0) begin
                send_gap <= send_gap - 1;
                req_ch.valid <= 1'b0;
            end else if (pending_reqs.size() > 0 && !hold_sender) begin
                r = pending_reqs.pop_front();
                req_ch.valid <= 1'b1;
                req_ch.action <= r.act;
                req_ch.request_bytes <= r.nbytes;
                req_ch.data_offset <= r.doff;
                send_gap <= gap_len();
            end else begin
                req_ch.valid <= 1'b0;
            end
        end
    end

    initial begin
        req_ch.valid = 1'b0;
        req_ch.action = 1'b0;
        req_ch.request_bytes = '0;
        req_ch.data_offset = '0;
        rsp_ch.ready = 1'b0;
    end

    // receiver stall and monitor
    int sink_gap = 0;
    always @(negedge i_clk) begin
        if (sink_gap > 0) begin
            sink_gap <= sink_gap - 1;
            rsp_ch.ready <= 1'b0;
        end else begin
            rsp_ch.ready <= 1'b1;
            sink_gap <= gap_len();
        end
    end

    always @(posedge i_clk) begin
        t_rsp e;
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            if (expected_rsps.size() == 0) begin
                report_mismatch("unexpected transaction", 1, 0);
            end else begin
                e = expected_rsps.pop_front();
                if (rsp_ch.result_offset !== e.off)
                    report_mismatch("result_offset", rsp_ch.result_offset, e.off);
                if (rsp_ch.granted_level !== e.lvl)
                    report_mismatch("granted_level", rsp_ch.granted_level, e.lvl);
                if (rsp_ch.status !== e.st)
                    report_mismatch("status", rsp_ch.status, e.st);
            end
        end
    end

    task automatic reg_write(logic [5:0] v);
        @(negedge i_clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= ADDR_HDR;
        pwdata <= APB_DW'(v);
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        hdr_sz = v;
    endtask

    task automatic wait_drained();
        while (pending_reqs.size() > 0 || req_ch.valid || expected_rsps.size() > 0)
            @(posedge i_clk);
        repeat (100) @(posedge i_clk);
    endtask

    function automatic void add_req(t_action a, int unsigned nb, int unsigned off);
        t_req r;
        r.act = a;
        r.nbytes = BYTES_W'(nb);
        r.doff = OFF_W'(off);
        pending_reqs.push_back(r);
    endfunction

    // live offsets are recorded by the model as each accepted allocate is
    // predicted; frees pick from the grants already seen
    function automatic void add_random(int unsigned k);
        int p, idx;
        p = $urandom_range(99);
        if (p < 45 || live_offs.size() == 0) begin
            case ($urandom_range(9))
                0: add_req(ACT_ALLOC, $urandom_range(65535), $urandom);
                1, 2: add_req(ACT_ALLOC, $urandom_range(4095), $urandom);
                default: add_req(ACT_ALLOC, $urandom_range(400), $urandom);
            endcase
        end else if (p < 90) begin
            idx = $urandom_range(live_offs.size() - 1);
            add_req(ACT_FREE, $urandom, live_offs[idx]);
            live_offs.delete(idx);
        end else if (p < 95) begin
            add_req(ACT_FREE, $urandom, $urandom_range(65535));
        end else begin
            add_req(ACT_FREE, $urandom, (k & 1) ? hdr_sz + 64 * $urandom_range(1023)
                                                : $urandom_range(63));
        end
    endfunction

    initial begin
        int unsigned hdrs[5];
        logic [5:0] h;
        hdrs = '{32, 1, 63, 17, 48};
        arena_reset();
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extremes, both actions, exhaustion, bad frees, merges
        add_req(ACT_ALLOC, 16'hFFFF, 16'hFFFF);
        add_req(ACT_ALLOC, 65535 - 32, 0);
        add_req(ACT_ALLOC, 0, 0);
        add_req(ACT_FREE, 0, 32);
        add_req(ACT_FREE, 0, 32);
        add_req(ACT_FREE, 0, 0);
        add_req(ACT_FREE, 0, 33);
        add_req(ACT_FREE, 0, 16'hFFFF);
        add_req(ACT_ALLOC, 0, 0);
        add_req(ACT_ALLOC, 31, 0);
        add_req(ACT_ALLOC, 32, 0);
        add_req(ACT_ALLOC, 1000, 0);
        add_req(ACT_ALLOC, 32768, 0);
        add_req(ACT_FREE, 0, 32 + 64);
        add_req(ACT_FREE, 0, 32);
        add_req(ACT_FREE, 0, 32 + 128);
        add_req(ACT_FREE, 0, 32 + 1024);
        add_req(ACT_FREE, 0, 32 + 2048);
        add_req(ACT_ALLOC, 16'h5555, 16'hAAAA);
        add_req(ACT_FREE, 16'hAAAA, 32);
        wait_drained();
        live_offs.delete();

        for (int ph = 0; ph < 5; ph++) begin
            h = 6'(hdrs[ph]);
            reg_write(h);
            // rebuild the live list from the model so frees stay meaningful
            live_offs.delete();
            for (int s = 0; s < NSLOT; s++)
                if (blk_used[s]) live_offs.push_back((s << MINL) + h);
            for (int k = 0; k < 290; k++) begin
                add_random(k);
                if (ph == 2 && k == 100) begin
                    wait_drained();
                    hold_sender = 1'b1;
                    repeat (20) @(posedge i_clk);
                    hold_sender = 1'b0;
                end
            end
            wait_drained();
        end

        if (n_errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial begin
        #8ms;
        $display("status: fail");
        $finish;
    end
endmodule

@@ files.f @@
src/bba_pkg.sv
src/bba_if.sv
src/bba_ram.sv
src/buddy_block_allocator.sv
tb/sv/tb_top.sv
